FILE: rtl/rwh_pkg.sv
// Shared types and codes for the readout word histogrammer.
package rwh_pkg;

  localparam int CHANNELS    = 64;
  localparam int NSETS       = 4;
  localparam int HIT_AW      = 8;
  localparam int MAX_BIN_W   = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int LIMIT_W     = 8;
  localparam int READ_W      = 32;

  localparam logic [LIMIT_W-1:0] ADC_LIMIT_RST = 8'd34;
  localparam logic [LIMIT_W-1:0] TDC_LIMIT_RST = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_LIMIT = 1'd0,
    REG_TDC_LIMIT = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_FILL      = 2'd0,
    OP_READ_SPEC = 2'd1,
    OP_READ_HIT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SRC_ADC_A = 2'd0,
    SRC_ADC_B = 2'd1,
    SRC_TDC   = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    ST_COUNTED   = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_BAD_CHAN  = 3'd2,
    ST_BAD_VALUE = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_READ      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_SPEC,
    SEL_HIT
  } rd_sel_t;

  // decoded request: status, bin addresses, update enables and result selection
  typedef struct packed {
    status_t               status;
    rd_sel_t               sel;
    logic                  hit_inc;
    logic                  spec_inc;
    logic [HIT_AW-1:0]     hit_addr;
    logic [MAX_BIN_W-1:0]  spec_bin;
  } req_t;

endpackage

FILE: rtl/readout_word_histogrammer.sv
// Readout word histogrammer top level: config registers, request stage, result register.
// An accepted request waits in the request stage; its result is registered at bin write-back,
//   which waits while a stalled result is held. No new request is taken before that write-back
//   (read then write-back of one bin through the single read and write port of each bin memory).
// Reset: limits return to 34 and 64; a clear sweep zeroes all bins, one address a cycle, over
//   256 * 2**clog2(SPECTRUM_BINS) spectrum addresses (2097152 at default), with in_ready low.
module readout_word_histogrammer #(
  parameter int SPECTRUM_BINS = 8192,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rwh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rwh_pkg::LIMIT_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic                            event_kind,
  input  logic [1:0]                      source,
  input  logic [31:0]                     data_word,
  input  logic [7:0]                      block_word_count,
  input  logic [1:0]                      read_set,
  input  logic [5:0]                      read_channel,
  input  logic [12:0]                     read_bin,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [rwh_pkg::READ_W-1:0]      read_count
);

  logic [rwh_pkg::LIMIT_W-1:0] adc_limit;
  logic [rwh_pkg::LIMIT_W-1:0] tdc_limit;
  rwh_pkg::req_t               req;
  rwh_pkg::req_t               s1_req;
  logic                        s1_valid;
  logic                        clearing;
  logic                        accept;
  logic                        wb_fire;
  logic [COUNT_WIDTH-1:0]      hit_q;
  logic [COUNT_WIDTH-1:0]      spec_q;
  logic [COUNT_WIDTH-1:0]      sel_cnt;
  logic [rwh_pkg::READ_W-1:0]  clip_cnt;

  assign cfg_ready = 1'b1;
  assign in_ready  = !clearing && !s1_valid;
  assign accept    = in_valid && in_ready;
  assign wb_fire   = s1_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_limit <= rwh_pkg::ADC_LIMIT_RST;
      tdc_limit <= rwh_pkg::TDC_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rwh_pkg::REG_ADC_LIMIT: adc_limit <= cfg_data;
        rwh_pkg::REG_TDC_LIMIT: tdc_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  rwh_decode #(
    .SPECTRUM_BINS(SPECTRUM_BINS)
  ) u_decode (
    .opcode          (opcode),
    .event_kind      (event_kind),
    .source          (source),
    .data_word       (data_word),
    .block_word_count(block_word_count),
    .read_set        (read_set),
    .read_channel    (read_channel),
    .read_bin        (read_bin),
    .adc_limit       (adc_limit),
    .tdc_limit       (tdc_limit),
    .req             (req)
  );

  rwh_bin_store #(
    .SPECTRUM_BINS(SPECTRUM_BINS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_req  (req),
    .wb_en   (wb_fire),
    .wb_req  (s1_req),
    .hit_q   (hit_q),
    .spec_q  (spec_q),
    .clearing(clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (wb_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
    end
  end

  always_comb begin
    case (s1_req.sel)
      rwh_pkg::SEL_SPEC: sel_cnt = spec_q;
      rwh_pkg::SEL_HIT:  sel_cnt = hit_q;
      default:           sel_cnt = '0;
    endcase
  end

  generate
    if (COUNT_WIDTH > rwh_pkg::READ_W) begin : g_clip
      assign clip_cnt = (|sel_cnt[COUNT_WIDTH-1:rwh_pkg::READ_W]) ? '1
                                                                  : sel_cnt[rwh_pkg::READ_W-1:0];
    end else begin : g_ext
      assign clip_cnt = rwh_pkg::READ_W'(sel_cnt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      status     <= s1_req.status;
      read_count <= clip_cnt;
    end
  end

endmodule

FILE: rtl/rwh_decode.sv
// Request decode: readout word to set, channel, value bin and status; read requests to bin addresses.
module rwh_decode #(
  parameter int SPECTRUM_BINS = 8192
) (
  input  logic [1:0]                   opcode,
  input  logic                         event_kind,
  input  logic [1:0]                   source,
  input  logic [31:0]                  data_word,
  input  logic [7:0]                   block_word_count,
  input  logic [1:0]                   read_set,
  input  logic [5:0]                   read_channel,
  input  logic [12:0]                  read_bin,
  input  logic [rwh_pkg::LIMIT_W-1:0]  adc_limit,
  input  logic [rwh_pkg::LIMIT_W-1:0]  tdc_limit,
  output rwh_pkg::req_t                req
);

  localparam logic [20:0] BINS_V = 21'(SPECTRUM_BINS);

  logic [20:0] tdc_val;

  assign tdc_val = {1'b0, data_word[19:0]};

  always_comb begin
    req          = '0;
    req.status   = rwh_pkg::ST_IGNORED;
    req.sel      = rwh_pkg::SEL_NONE;
    case (opcode)
      rwh_pkg::OP_FILL: begin
        if (source == rwh_pkg::SRC_TDC) begin
          if (block_word_count > tdc_limit) begin
            req.status = rwh_pkg::ST_TOO_LONG;
          end else if (data_word[30]) begin
            req.status = rwh_pkg::ST_BAD_CHAN;
          end else begin
            req.hit_inc  = 1'b1;
            req.hit_addr = {1'b1, event_kind, data_word[29:24]};
            req.spec_bin = data_word[15:0];
            if (tdc_val >= BINS_V) begin
              req.status = rwh_pkg::ST_BAD_VALUE;
            end else begin
              req.spec_inc = 1'b1;
              req.status   = rwh_pkg::ST_COUNTED;
            end
          end
        end else if (source == rwh_pkg::SRC_ADC_A ||
                     (source == rwh_pkg::SRC_ADC_B && event_kind)) begin
          if (block_word_count > adc_limit) begin
            req.status = rwh_pkg::ST_TOO_LONG;
          end else begin
            // 12-bit value is counted without a range check; it fits when SPECTRUM_BINS is at least 4096
            req.hit_inc  = 1'b1;
            req.spec_inc = 1'b1;
            req.hit_addr = {1'b0, event_kind, source == rwh_pkg::SRC_ADC_B,
                            data_word[20:16]};
            req.spec_bin = {4'd0, data_word[11:0]};
            req.status   = rwh_pkg::ST_COUNTED;
          end
        end
      end
      rwh_pkg::OP_READ_SPEC: begin
        req.status   = rwh_pkg::ST_READ;
        req.hit_addr = {read_set, read_channel};
        req.spec_bin = {3'd0, read_bin};
        if ({8'd0, read_bin} < BINS_V) begin
          req.sel = rwh_pkg::SEL_SPEC;
        end
      end
      rwh_pkg::OP_READ_HIT: begin
        req.status   = rwh_pkg::ST_READ;
        req.hit_addr = {read_set, read_channel};
        req.sel      = rwh_pkg::SEL_HIT;
      end
      default: begin
        req.status = rwh_pkg::ST_IGNORED;
      end
    endcase
  end

endmodule

FILE: rtl/rwh_bin_store.sv
// Spectrum and hit-pattern bin memories with read-modify-write and clear sweep.
module rwh_bin_store #(
  parameter int SPECTRUM_BINS = 8192,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  rwh_pkg::req_t          rd_req,
  input  logic                   wb_en,
  input  rwh_pkg::req_t          wb_req,
  output logic [COUNT_WIDTH-1:0] hit_q,
  output logic [COUNT_WIDTH-1:0] spec_q,
  output logic                   clearing
);

  localparam int BIN_W   = $clog2(SPECTRUM_BINS);
  localparam int SPEC_AW = rwh_pkg::HIT_AW + BIN_W;
  localparam int SPEC_DEPTH = 2 ** SPEC_AW;
  localparam int HIT_DEPTH  = 2 ** rwh_pkg::HIT_AW;

  logic [COUNT_WIDTH-1:0] spec_mem [SPEC_DEPTH];
  logic [COUNT_WIDTH-1:0] hit_mem  [HIT_DEPTH];

  logic [SPEC_AW-1:0]     clr_addr;
  logic [SPEC_AW-1:0]     rd_spec_addr;
  logic [SPEC_AW-1:0]     wb_spec_addr;
  logic [COUNT_WIDTH-1:0] hit_inc_val;
  logic [COUNT_WIDTH-1:0] spec_inc_val;

  assign rd_spec_addr = {rd_req.hit_addr, rd_req.spec_bin[BIN_W-1:0]};
  assign wb_spec_addr = {wb_req.hit_addr, wb_req.spec_bin[BIN_W-1:0]};
  assign hit_inc_val  = (&hit_q)  ? hit_q  : hit_q + 1'b1;
  assign spec_inc_val = (&spec_q) ? spec_q : spec_q + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      spec_mem[clr_addr] <= '0;
    end else if (wb_en && wb_req.spec_inc) begin
      spec_mem[wb_spec_addr] <= spec_inc_val;
    end
    if (rd_en) begin
      spec_q <= spec_mem[rd_spec_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      hit_mem[clr_addr[rwh_pkg::HIT_AW-1:0]] <= '0;
    end else if (wb_en && wb_req.hit_inc) begin
      hit_mem[wb_req.hit_addr] <= hit_inc_val;
    end
    if (rd_en) begin
      hit_q <= hit_mem[rd_req.hit_addr];
    end
  end

endmodule

FILE: rtl/rwh_checker.sv
// Port-level checks for the readout word histogrammer, bound to the top level.
module rwh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] read_count
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("request or result open right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_count))
    else $error("stalled result changed");

  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous bin update pending");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rwh_pkg::ST_READ |-> read_count == '0)
    else $error("nonzero count on a non-read result");

endmodule

bind readout_word_histogrammer rwh_checker u_rwh_checker (.*);
